[sv/vppi_pkg.sv]
// Package for the video processor port interface.
// Holds the action codes, access codes, field widths and display register masks.
// No dependencies.
package vppi_pkg;

  localparam int unsigned ADDR_W   = 14;
  localparam int unsigned NUM_REGS = 11;

  typedef enum logic [2:0] {
    ACT_DATA_RD   = 3'd0,
    ACT_DATA_WR   = 3'd1,
    ACT_STATUS_RD = 3'd2,
    ACT_CTRL_WR   = 3'd3,
    ACT_SPRITE    = 3'd4
  } action_e;

  localparam logic [1:0] CODE_REG  = 2'd2;
  localparam logic [1:0] CODE_CRAM = 2'd3;

  typedef struct packed {
    logic [7:0] reg_value;
    logic [3:0] reg_index;
    logic       reg_written;
    logic [7:0] read_data;
  } result_t;

  function automatic logic [7:0] reg_mask(input logic [3:0] idx, input logic old_model);
    logic [7:0] m;
    case (idx)
      4'd0:    m = old_model ? 8'h03 : 8'hFF;
      4'd1:    m = 8'hFB;
      4'd2:    m = 8'h0F;
      4'd4:    m = 8'h07;
      4'd5:    m = 8'h7F;
      4'd6:    m = 8'h07;
      default: m = 8'hFF;
    endcase
    return m;
  endfunction

endpackage

[sv/video_processor_port_interface.sv]
// Top level of the video processor port interface: bus port decode, access
// address and latch, video RAM and color RAM. Depends on vppi_pkg.
//
// The block takes one item every cycle while the output is not stalled. Each
// result passes through the synchronous read of video or color RAM and then
// the output register. Every item makes at most one access to one memory
// port, and the address state is updated in the cycle the item is accepted,
// so the next item follows at once. A stalled output holds at most two
// results, after which the input stalls.
module video_processor_port_interface #(
  parameter int unsigned VRAM_ADDR_BITS = 14,
  parameter int unsigned CRAM_ENTRIES   = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic        cfg_data_i,      // old_model_mode
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [7:0] write_byte, [8] in_vblank, [13:9] sprite_number,
  // [14] sprite_collision, [15] sprite_overflow
  input  logic [15:0] s_axis_tdata,
  input  logic [2:0]  s_axis_tuser,    // [2:0] action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // [7:0] read_data, [8] reg_written, [12:9] reg_index, [20:13] reg_value
  output logic [23:0] m_axis_tdata
);
  import vppi_pkg::*;

  localparam int unsigned VramDepth = 1 << VRAM_ADDR_BITS;
  localparam int unsigned CramBits  = $clog2(CRAM_ENTRIES);

  logic [ADDR_W-1:0] addr_q, addr_d;
  logic [1:0]        code_q, code_d;
  logic              pend_q, pend_d;
  logic [4:0]        fifth_q, fifth_d;
  logic              coll_q, coll_d;
  logic              ovf_q, ovf_d;
  logic              old_q;

  logic [7:0] vram_q [VramDepth];
  logic [7:0] cram_q [CRAM_ENTRIES];
  logic [7:0] vram_rdata_q;
  logic [7:0] cram_rdata_q;

  logic    s1_valid_q, s1_mem_q, s1_cram_q;
  result_t s1_res_q, s1_res_d, s1_out;
  logic    out_valid_q;
  result_t out_q;

  logic                      in_acc, s1_adv;
  logic [2:0]                action;
  logic [7:0]                wbyte;
  logic                      vram_we, vram_re, cram_we, cram_re;
  logic [VRAM_ADDR_BITS-1:0] vram_idx;
  logic [CramBits-1:0]       cram_idx;
  logic [3:0]                ridx;

  assign action   = s_axis_tuser;
  assign wbyte    = s_axis_tdata[7:0];
  assign vram_idx = VRAM_ADDR_BITS'(addr_q);
  assign cram_idx = addr_q[CramBits-1:0];
  assign ridx     = old_q ? {1'b0, addr_q[2:0]} : addr_q[3:0];

  assign s1_adv        = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_adv;
  assign in_acc        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    addr_d   = addr_q;
    code_d   = code_q;
    pend_d   = pend_q;
    fifth_d  = fifth_q;
    coll_d   = coll_q;
    ovf_d    = ovf_q;
    s1_res_d = '0;
    vram_we  = 1'b0;
    vram_re  = 1'b0;
    cram_we  = 1'b0;
    cram_re  = 1'b0;
    case (action)
      ACT_DATA_RD: begin
        cram_re = (code_q == CODE_CRAM);
        vram_re = (code_q != CODE_CRAM);
        addr_d  = addr_q + ADDR_W'(1);
      end
      ACT_DATA_WR: begin
        if (code_q == CODE_CRAM) begin
          cram_we = 1'b1;
        end else if (code_q == CODE_REG) begin
          if (32'(ridx) < NUM_REGS) begin
            s1_res_d.reg_written = 1'b1;
            s1_res_d.reg_index   = ridx;
            s1_res_d.reg_value   = wbyte & reg_mask(ridx, old_q);
          end
        end else begin
          vram_we = 1'b1;
        end
        addr_d = addr_q + ADDR_W'(1);
      end
      ACT_STATUS_RD: begin
        s1_res_d.read_data = {s_axis_tdata[8], ovf_q, coll_q, fifth_q};
        pend_d  = 1'b0;
        fifth_d = '0;
        coll_d  = 1'b0;
        ovf_d   = 1'b0;
      end
      ACT_CTRL_WR: begin
        if (!pend_q) begin
          addr_d = {addr_q[13:8], wbyte};
          pend_d = 1'b1;
        end else begin
          addr_d = {wbyte[5:0], addr_q[7:0]};
          code_d = wbyte[7:6];
          pend_d = 1'b0;
        end
      end
      ACT_SPRITE: begin
        fifth_d = s_axis_tdata[13:9];
        coll_d  = coll_q | s_axis_tdata[14];
        ovf_d   = ovf_q | s_axis_tdata[15];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      addr_q      <= '0;
      code_q      <= '0;
      pend_q      <= 1'b0;
      fifth_q     <= '0;
      coll_q      <= 1'b0;
      ovf_q       <= 1'b0;
      old_q       <= 1'b0;
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        old_q <= cfg_data_i;
      end
      if (in_acc) begin
        addr_q  <= addr_d;
        code_q  <= code_d;
        pend_q  <= pend_d;
        fifth_q <= fifth_d;
        coll_q  <= coll_d;
        ovf_q   <= ovf_d;
      end
      if (in_acc) begin
        s1_valid_q <= 1'b1;
      end else if (s1_adv) begin
        s1_valid_q <= 1'b0;
      end
      if (s1_adv) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_res_q  <= s1_res_d;
      s1_mem_q  <= vram_re || cram_re;
      s1_cram_q <= cram_re;
    end
    if (s1_adv) begin
      out_q <= s1_out;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && vram_we) begin
      vram_q[vram_idx] <= wbyte;
    end
    if (in_acc && vram_re) begin
      vram_rdata_q <= vram_q[vram_idx];
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && cram_we) begin
      cram_q[cram_idx] <= wbyte;
    end
    if (in_acc && cram_re) begin
      cram_rdata_q <= cram_q[cram_idx];
    end
  end

  always_comb begin
    s1_out = s1_res_q;
    if (s1_mem_q) begin
      s1_out.read_data = s1_cram_q ? cram_rdata_q : vram_rdata_q;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {3'b000, out_q};

endmodule

[sv/vppi_checker.sv]
// Port-level checker for the video processor port interface, with its bind.
// Depends on vppi_pkg and on video_processor_port_interface.
module vppi_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        s_axis_tvalid,
  input logic        s_axis_tready,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [23:0] m_axis_tdata
);
  import vppi_pkg::*;

  logic [7:0] chk_rmask;
  assign chk_rmask = reg_mask(m_axis_tdata[12:9], 1'b0);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("output item changed while stalled");

  a_ready_when_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input stalled with empty output");

  a_reg_fields_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[8] |-> m_axis_tdata[23:9] == '0)
    else $error("register fields set without a register write");

  a_reg_defined: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[8] |->
      32'(m_axis_tdata[12:9]) < NUM_REGS && m_axis_tdata[7:0] == '0 &&
      (m_axis_tdata[20:13] & ~chk_rmask) == '0)
    else $error("register write outside defined registers or bits");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> ##1 m_axis_tvalid)
    else $error("result missing after accepted item");

endmodule

bind video_processor_port_interface vppi_checker u_vppi_checker (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);

[test/testbench.sv]
// Testbench for video_processor_port_interface: directed port tests, then random
// bus traffic checked item by item against an in-bench model of the ports.
// Depends on vppi_pkg and the block under test; reads no files.
`timescale 1ns / 100ps

module testbench;
  import vppi_pkg::*;

  localparam int unsigned CLK_PERIOD   = 4;
  localparam int unsigned RUN_LIMIT_NS = 4_000_000;
  localparam int unsigned VRAM_DEPTH   = 1 << ADDR_W;
  localparam int unsigned CRAM_DEPTH   = 64;
  localparam int unsigned MAX_REPORTS  = 100;

  localparam logic [1:0] CODE_VRAM_RD = 2'd0;
  localparam logic [1:0] CODE_VRAM_WR = 2'd1;
  localparam logic [2:0] ACT_LAST     = 3'd7;
  localparam logic [3:0] MODE_REG     = 4'd0;
  localparam logic [7:0] MODE_REG_OLD_BITS = 8'h03;
  // defined bits per display register, register 10 first
  localparam logic [NUM_REGS-1:0][7:0] REG_BITS =
    {8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h07, 8'h7F, 8'h07, 8'hFF, 8'h0F, 8'hFB, 8'hFF};

  logic        clk_i = 1'b0;
  logic        rst_ni;
  logic        cfg_we_i;
  logic        cfg_data_i;
  logic        s_axis_tvalid;
  logic        s_axis_tready;
  logic [15:0] s_axis_tdata;
  logic [2:0]  s_axis_tuser;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;

  // port model state
  logic [7:0]  vram_img [0:VRAM_DEPTH-1];
  bit          vram_seen [0:VRAM_DEPTH-1];
  logic [7:0]  cram_img [0:CRAM_DEPTH-1];
  bit          cram_seen [0:CRAM_DEPTH-1];
  logic [7:0]  regs_img [0:NUM_REGS-1];
  logic [13:0] addr_q = '0;
  logic [1:0]  code_q = '0;
  logic        latch_q = 1'b0;
  logic [4:0]  fifth_q = '0;
  logic        coll_q = 1'b0;
  logic        ovf_q = 1'b0;
  logic        old_model_q = 1'b0;

  result_t     expected_q [$];
  int unsigned fail_cnt = 0;
  int unsigned items_sent = 0;
  bit          bursts_on = 1'b1;
  int unsigned stall_left = 0;

  video_processor_port_interface dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_data_i    (cfg_data_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  function automatic result_t apply_bus_access(input logic [2:0] act,
                                               input logic [15:0] payload);
    result_t    r;
    logic [3:0] rn;
    logic [7:0] wb;
    logic [7:0] bits;
    r  = '0;
    wb = payload[7:0];
    case (act)
      ACT_DATA_RD: begin
        if (code_q == CODE_CRAM) r.read_data = cram_img[addr_q[5:0]];
        else r.read_data = vram_img[addr_q];
        addr_q = addr_q + 14'd1;
      end
      ACT_DATA_WR: begin
        if (code_q == CODE_CRAM) begin
          cram_img[addr_q[5:0]]  = wb;
          cram_seen[addr_q[5:0]] = 1'b1;
        end else if (code_q == CODE_REG) begin
          rn = old_model_q ? {1'b0, addr_q[2:0]} : addr_q[3:0];
          if (rn < NUM_REGS) begin
            bits = (old_model_q && rn == MODE_REG) ? MODE_REG_OLD_BITS : REG_BITS[rn];
            regs_img[rn]  = wb & bits;
            r.reg_written = 1'b1;
            r.reg_index   = rn;
            r.reg_value   = regs_img[rn];
          end
        end else begin
          vram_img[addr_q]  = wb;
          vram_seen[addr_q] = 1'b1;
        end
        addr_q = addr_q + 14'd1;
      end
      ACT_STATUS_RD: begin
        r.read_data = {payload[8], ovf_q, coll_q, fifth_q};
        latch_q = 1'b0;
        fifth_q = '0;
        coll_q  = 1'b0;
        ovf_q   = 1'b0;
      end
      ACT_CTRL_WR: begin
        if (!latch_q) begin
          addr_q[7:0] = wb;
          latch_q     = 1'b1;
        end else begin
          addr_q[13:8] = wb[5:0];
          code_q       = wb[7:6];
          latch_q      = 1'b0;
        end
      end
      ACT_SPRITE: begin
        fifth_q = payload[13:9];
        coll_q  = coll_q | payload[14];
        ovf_q   = ovf_q | payload[15];
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic bit target_written();
    if (code_q == CODE_CRAM) return cram_seen[addr_q[5:0]];
    return vram_seen[addr_q];
  endfunction

  function automatic logic [13:0] pick_address();
    logic [5:0] hi;
    logic [7:0] lo;
    case ($urandom_range(0, 3))
      0: hi = 6'h00;
      1: hi = 6'h3F;
      2: hi = 6'h15;
      default: hi = 6'($urandom);
    endcase
    if ($urandom_range(0, 1) == 0) lo = 8'($urandom);
    else lo = 8'($urandom_range(0, 15)) - 8'd8;
    return {hi, lo};
  endfunction

  task automatic check_field(input string what, input logic [7:0] want,
                             input logic [7:0] got);
    if (got !== want) begin
      fail_cnt++;
      if (fail_cnt <= MAX_REPORTS)
        $display("%0t: %s expected %02h actual %02h", $time, what, want, got);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_q.size() == 0) begin
        fail_cnt++;
        if (fail_cnt <= MAX_REPORTS)
          $display("%0t: result expected none actual %06h", $time, m_axis_tdata);
      end else begin
        want = expected_q.pop_front();
        check_field("read_data", want.read_data, m_axis_tdata[7:0]);
        check_field("reg_written", 8'(want.reg_written), 8'(m_axis_tdata[8]));
        check_field("reg_index", 8'(want.reg_index), 8'(m_axis_tdata[12:9]));
        check_field("reg_value", want.reg_value, m_axis_tdata[20:13]);
      end
    end
  end

  always @(negedge clk_i) begin
    if (stall_left != 0) begin
      stall_left--;
      m_axis_tready = 1'b0;
    end else if (bursts_on && $urandom_range(0, 7) == 0) begin
      stall_left    = $urandom_range(1, 11) - 1;
      m_axis_tready = 1'b0;
    end else begin
      m_axis_tready = 1'b1;
    end
  end

  task automatic idle_input(input int unsigned cycles);
    repeat (cycles) begin
      @(negedge clk_i);
      s_axis_tvalid = 1'b0;
    end
  endtask

  task automatic put_item(input logic [2:0] act, input logic [7:0] wbyte,
                          input logic vb, input logic [4:0] spr,
                          input logic coll, input logic ovf);
    result_t r;
    if (bursts_on && $urandom_range(0, 5) == 0) idle_input($urandom_range(1, 11));
    @(negedge clk_i);
    s_axis_tvalid = 1'b1;
    s_axis_tuser  = act;
    s_axis_tdata  = {ovf, coll, spr, vb, wbyte};
    do @(posedge clk_i); while (!s_axis_tready);
    r = apply_bus_access(act, s_axis_tdata);
    expected_q.push_back(r);
    items_sent++;
  endtask

  task automatic put_op(input logic [2:0] act, input logic [7:0] wbyte);
    put_item(act, wbyte, 1'($urandom), 5'($urandom),
             $urandom_range(0, 3) == 0, $urandom_range(0, 3) == 0);
  endtask

  task automatic set_access(input logic [13:0] addr, input logic [1:0] code);
    if (latch_q) put_op(ACT_STATUS_RD, 8'($urandom));
    put_op(ACT_CTRL_WR, addr[7:0]);
    put_op(ACT_CTRL_WR, {code, addr[13:8]});
  endtask

  task automatic data_access(input bit want_read);
    if (want_read && target_written()) put_op(ACT_DATA_RD, 8'($urandom));
    else put_op(ACT_DATA_WR, 8'($urandom));
  endtask

  task automatic wait_drained(input int unsigned max_cycles);
    int unsigned n;
    n = 0;
    while (expected_q.size() != 0 && n < max_cycles) begin
      @(posedge clk_i);
      n++;
    end
    repeat (4) @(posedge clk_i);
  endtask

  task automatic set_old_model(input logic mode);
    idle_input(1);
    wait_drained(20000);
    @(negedge clk_i);
    cfg_we_i   = 1'b1;
    cfg_data_i = mode;
    @(negedge clk_i);
    cfg_we_i    = 1'b0;
    old_model_q = mode;
  endtask

  task automatic run_traffic(input int unsigned n_items);
    int unsigned stop_at;
    int unsigned pick;
    int unsigned n;
    logic [13:0] base;
    logic [1:0]  wcode;
    logic [1:0]  rcode;
    stop_at = items_sent + n_items;
    while (items_sent < stop_at) begin
      pick = $urandom_range(0, 99);
      if (pick < 55) begin
        set_access(pick_address(), 2'($urandom));
        repeat ($urandom_range(1, 8)) data_access($urandom_range(0, 1));
      end else if (pick < 80) begin
        base  = pick_address();
        n     = $urandom_range(1, 8);
        wcode = ($urandom_range(0, 2) == 0) ? CODE_CRAM : CODE_VRAM_WR;
        rcode = ($urandom_range(0, 1) == 0) ? CODE_VRAM_RD : CODE_REG;
        set_access(base, wcode);
        repeat (n) put_op(ACT_DATA_WR, 8'($urandom));
        set_access(base, (wcode == CODE_CRAM) ? CODE_CRAM : rcode);
        repeat (n) data_access(1'b1);
      end else if (pick < 88) begin
        put_op(ACT_SPRITE, 8'($urandom));
        if ($urandom_range(0, 1) == 0) put_op(ACT_STATUS_RD, 8'($urandom));
      end else if (pick < 95) begin
        // broken control sequences: lone first byte, status read or data access in between
        put_op(ACT_CTRL_WR, 8'($urandom));
        case ($urandom_range(0, 2))
          0: put_op(ACT_STATUS_RD, 8'($urandom));
          1: data_access($urandom_range(0, 1));
          default: ;
        endcase
        if ($urandom_range(0, 1) == 0) put_op(ACT_CTRL_WR, 8'($urandom));
      end else begin
        put_op(3'($urandom_range(ACT_SPRITE + 1, ACT_LAST)), 8'($urandom));
      end
    end
  endtask

  task automatic test_status_flags();
    put_item(ACT_STATUS_RD, 8'h00, 1'b1, 5'h00, 1'b0, 1'b0);
    put_item(ACT_SPRITE, 8'hFF, 1'b0, 5'h1F, 1'b1, 1'b1);
    put_item(ACT_SPRITE, 8'h00, 1'b1, 5'h00, 1'b0, 1'b0);
    put_item(ACT_STATUS_RD, 8'hFF, 1'b0, 5'h1F, 1'b1, 1'b1);
    put_item(ACT_STATUS_RD, 8'h00, 1'b1, 5'h15, 1'b0, 1'b1);
  endtask

  task automatic test_address_wrap();
    set_access(14'h3FFF, CODE_VRAM_WR);
    put_op(ACT_DATA_WR, 8'hFF);
    put_op(ACT_DATA_WR, 8'h00);
    set_access(14'h3FFF, CODE_REG);
    put_op(ACT_DATA_RD, 8'h00);
    put_op(ACT_DATA_RD, 8'hFF);
  endtask

  task automatic test_color_ram();
    set_access(14'h3FFF, CODE_CRAM);
    put_op(ACT_DATA_WR, 8'hA5);
    put_op(ACT_DATA_WR, 8'h5A);
    set_access(14'h3FFF, CODE_CRAM);
    put_op(ACT_DATA_RD, 8'h00);
    put_op(ACT_DATA_RD, 8'h00);
  endtask

  task automatic test_registers();
    set_access(14'h000A, CODE_REG);
    put_op(ACT_DATA_WR, 8'hFF);
    put_op(ACT_DATA_WR, 8'hFF);
    put_op(ACT_LAST, 8'hFF);
  endtask

  task automatic test_mixed_traffic();
    run_traffic(550);
  endtask

  task automatic test_old_model_traffic();
    set_old_model(1'b1);
    run_traffic(500);
  endtask

  task automatic test_steady_stream();
    bursts_on = 1'b0;
    set_old_model(1'b0);
    run_traffic(250);
    set_old_model(1'b1);
    run_traffic(200);
  endtask

  initial begin
    rst_ni        = 1'b0;
    cfg_we_i      = 1'b0;
    cfg_data_i    = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    set_old_model(1'b0);
    test_status_flags();
    test_address_wrap();
    test_color_ram();
    test_registers();
    test_mixed_traffic();
    test_old_model_traffic();
    test_steady_stream();

    idle_input(1);
    wait_drained(20000);
    if (expected_q.size() != 0) begin
      fail_cnt += expected_q.size();
      $display("%0t: results expected %0d actual 0", $time, expected_q.size());
    end
    if (fail_cnt == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
